@@ sv/assert_macros.svh @@
// assertion helper macros shared by the tone generator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define STG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define STG_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define STG_ASSERT(lbl, clk, rst_n, prop)
`define STG_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ sv/stgen_pkg.sv @@
// shared types, constants and the sine lookup for the tone generator
package stgen_pkg;

    // default sizes
    localparam int STG_TABLE_DEPTH = 128;
    localparam int STG_PHASE_WIDTH = 16;

    // field widths
    localparam int OP_W    = 2;
    localparam int STEP_W  = 8;
    localparam int LEN_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int TICKS_W = 21;
    localparam int ENV_W   = 7;
    localparam int SINE_W  = 8;
    localparam int SPTS_W  = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // envelope
    localparam logic [ENV_W-1:0] ENV_FULL  = 7'd64;
    localparam int               ENV_SHIFT = 6;

    // tick count = floor(length * 1000 / 51), split as whole part plus remainder
    localparam int unsigned TICK_SCALE   = 1000;
    localparam int unsigned TICK_DIV     = 51;
    localparam int unsigned TICK_WHOLE   = TICK_SCALE / TICK_DIV;
    localparam int unsigned TICK_REM     = TICK_SCALE % TICK_DIV;
    localparam int          TICK_SHIFT   = 29;
    localparam int          TICK_RECIP_W = 24;
    localparam longint unsigned TICK_RECIP =
        ((64'd1 << TICK_SHIFT) + 64'(TICK_DIV) - 64'd1) / 64'(TICK_DIV);
    localparam logic [TICK_RECIP_W-1:0] TICK_RECIP_V = TICK_RECIP_W'(TICK_RECIP);

    // sine quarter wave, 128 points per period
    localparam logic [6:0] QUARTER_WAVE [0:32] = '{
        7'd0,   7'd6,   7'd12,  7'd19,  7'd25,  7'd31,  7'd37,  7'd43,  7'd49,
        7'd54,  7'd60,  7'd65,  7'd71,  7'd76,  7'd81,  7'd85,  7'd90,  7'd94,
        7'd98,  7'd102, 7'd106, 7'd109, 7'd112, 7'd115, 7'd117, 7'd120, 7'd122,
        7'd123, 7'd125, 7'd126, 7'd126, 7'd127, 7'd127
    };

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic stop;
        logic start_mul;
        logic start_fin;
        logic tk_acc;
        logic tk_div;
        logic tk_mod;
        logic tk_scl;
        logic tk_att;
        logic tk_rel;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic active;
    } t_dp_stat;

    // unsigned sine sample centered on 128 for a point of a 128-point period
    function automatic logic [SINE_W-1:0] sine_at(input logic [SPTS_W-1:0] p);
        logic [SPTS_W-1:0] a;
        logic [6:0]        mag;
        if (p <= 7'd32) begin
            a = p;
        end else if (p <= 7'd64) begin
            a = 7'd64 - p;
        end else if (p <= 7'd96) begin
            a = p - 7'd64;
        end else begin
            a = 7'(8'd128 - {1'b0, p});
        end
        mag = QUARTER_WAVE[a[5:0]];
        if (p <= 7'd64) begin
            return 8'd128 + {1'b0, mag};
        end else begin
            return 8'd128 - {1'b0, mag};
        end
    endfunction

endpackage

@@ sv/sine_tone_generator_with_envelope_core.sv @@
// top level of the sine tone generator with attack and release envelope
// Input channel (i_valid / o_stall) carries one item per operation: a sample
// tick, a tone start (i_step_size, i_length) or an output disconnect. Each
// item yields exactly one result on the output channel (o_valid / i_stall):
// the PWM compare level, the playing flag and the output enable flag.
// A tick while playing runs a six-step sequence through one shared datapath
// (phase add, reciprocal multiply and remainder for the table index, a second
// multiply for the table point, then sine times attack and times release) and
// its result is loaded in the write state; a start first runs the
// length-to-tick-count multiply and load; every other item goes straight to
// the write state. The next item is taken only after the load.
// A new item is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register. If the receiver stalls, that
// result holds and the next finished item waits in the sequencer, which
// stalls the input until the output register frees.
// Synchronous active-low reset clears the tone state, turns the output
// enable on and empties the output register; no clearing pass is needed.
module sine_tone_generator_with_envelope_core
    import stgen_pkg::*;
#(
    parameter int TABLE_DEPTH = STG_TABLE_DEPTH,
    parameter int PHASE_WIDTH = STG_PHASE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [STEP_W-1:0]  i_step_size,
    input  logic [LEN_W-1:0]   i_length,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [LEVEL_W-1:0] o_pwm_level,
    output logic               o_playing,
    output logic               o_output_enabled
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    stgen_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath
    stgen_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_step_size      (i_step_size),
        .i_length         (i_length),
        .o_pwm_level      (o_pwm_level),
        .o_playing        (o_playing),
        .o_output_enabled (o_output_enabled)
    );

endmodule

@@ sv/stgen_ctrl.sv @@
// sequencer for the tone generator: handshakes and datapath step commands
`include "assert_macros.svh"

module stgen_ctrl
    import stgen_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [OP_W-1:0] i_operation,
    output logic            o_valid,
    input  logic            i_stall,
    input  t_dp_stat        i_stat,
    output t_dp_cmd         o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_LOAD   = 4'd2;
    localparam logic [3:0] ST_TK_ACC = 4'd3;
    localparam logic [3:0] ST_TK_DIV = 4'd4;
    localparam logic [3:0] ST_TK_MOD = 4'd5;
    localparam logic [3:0] ST_TK_SCL = 4'd6;
    localparam logic [3:0] ST_TK_ATT = 4'd7;
    localparam logic [3:0] ST_TK_REL = 4'd8;
    localparam logic [3:0] ST_WRITE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign w_slot_free = !r_out_valid || !i_stall;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_operation)
                        OP_TICK: begin
                            n_state = i_stat.active ? ST_TK_ACC : ST_WRITE;
                        end
                        OP_START: begin
                            n_state = ST_START;
                        end
                        OP_STOP: begin
                            o_cmd.stop = 1'b1;
                            n_state    = ST_WRITE;
                        end
                        default: begin
                            n_state = ST_WRITE;
                        end
                    endcase
                end
            end
            ST_START: begin
                o_cmd.start_mul = 1'b1;
                n_state         = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.start_fin = 1'b1;
                n_state         = ST_WRITE;
            end
            ST_TK_ACC: begin
                o_cmd.tk_acc = 1'b1;
                n_state      = ST_TK_DIV;
            end
            ST_TK_DIV: begin
                o_cmd.tk_div = 1'b1;
                n_state      = ST_TK_MOD;
            end
            ST_TK_MOD: begin
                o_cmd.tk_mod = 1'b1;
                n_state      = ST_TK_SCL;
            end
            ST_TK_SCL: begin
                o_cmd.tk_scl = 1'b1;
                n_state      = ST_TK_ATT;
            end
            ST_TK_ATT: begin
                o_cmd.tk_att = 1'b1;
                n_state      = ST_TK_REL;
            end
            ST_TK_REL: begin
                o_cmd.tk_rel = 1'b1;
                n_state      = ST_WRITE;
            end
            ST_WRITE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid: set when a result is loaded, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `STG_ASSERT(a_out_from_write, i_clk, i_rst_n, $rose(o_valid) |-> $past(r_state == ST_WRITE))
    `STG_ASSERT(a_write_waits, i_clk, i_rst_n, (r_state == ST_WRITE && r_out_valid && i_stall) |=> (r_state == ST_WRITE))
    `STG_ASSERT_NEVER(a_load_blocked, i_clk, i_rst_n, o_cmd.out_load && r_out_valid && i_stall)

endmodule

@@ sv/stgen_dp.sv @@
// datapath: tone state, phase to table index, sine lookup and envelope scaling
`include "assert_macros.svh"

module stgen_dp
    import stgen_pkg::*;
#(
    parameter int TABLE_DEPTH = STG_TABLE_DEPTH,
    parameter int PHASE_WIDTH = STG_PHASE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [STEP_W-1:0]  i_step_size,
    input  logic [LEN_W-1:0]   i_length,
    output logic [LEVEL_W-1:0] o_pwm_level,
    output logic               o_playing,
    output logic               o_output_enabled
);

    // rounded phase value and index sizes
    localparam int VW  = PHASE_WIDTH - 3;
    localparam int IW  = $clog2(TABLE_DEPTH);
    // index = v mod depth by reciprocal multiply
    localparam int K1  = VW + IW;
    localparam int M1W = VW + 2;
    localparam longint unsigned M1 =
        ((64'd1 << K1) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
    localparam logic [M1W-1:0] M1_V = M1W'(M1);
    localparam int P1W = VW + M1W;
    // table point = index * 128 / depth by reciprocal multiply
    localparam int YW  = IW + SPTS_W;
    localparam int K2  = YW + IW;
    localparam int M2W = IW + 9;
    localparam longint unsigned M2 =
        ((64'd1 << K2) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
    localparam logic [M2W-1:0] M2_V = M2W'(M2);
    localparam int P2W = YW + M2W;
    localparam logic [IW:0] DEPTH_V = (IW + 1)'(TABLE_DEPTH);

    // tone state
    logic [PHASE_WIDTH-1:0] r_phase;
    logic [STEP_W-1:0]      r_step;
    logic [TICKS_W-1:0]     r_ticks;
    logic [ENV_W-1:0]       r_attack;
    logic [ENV_W-1:0]       r_release;
    logic                   r_active;
    logic                   r_drive;
    logic [LEVEL_W-1:0]     r_level;

    // working registers
    logic [STEP_W-1:0]                  r_step_in;
    logic [LEN_W-1:0]                   r_len;
    logic [TICKS_W-1:0]                 r_len_rem;
    logic [TICKS_W+TICK_RECIP_W-1:0]    r_sprod;
    logic                               r_end;
    logic [P1W-1:0]                     r_prod1;
    logic [IW-1:0]                      r_idx;
    logic [P2W-1:0]                     r_prod2;
    logic [LEVEL_W-1:0]                 r_sa;

    // output register
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_playing;
    logic               r_out_drive;

    logic [PHASE_WIDTH-1:0] w_phase4;
    logic [VW-1:0]          w_v;
    logic [VW-1:0]          w_q;
    logic [VW+IW:0]         w_qd;
    logic [VW-1:0]          w_rem;
    logic [SINE_W-1:0]      w_sine;
    logic [SINE_W+ENV_W-1:0] w_sa_full;
    logic [LEVEL_W+ENV_W-1:0] w_lvl_full;

    assign o_stat.active    = r_active;
    assign o_pwm_level      = r_out_level;
    assign o_playing        = r_out_playing;
    assign o_output_enabled = r_out_drive;

    // index arithmetic
    assign w_phase4   = r_phase + PHASE_WIDTH'(4);
    assign w_v        = w_phase4[PHASE_WIDTH-1:3];
    assign w_q        = VW'(r_prod1 >> K1);
    assign w_qd       = w_q * DEPTH_V;
    assign w_rem      = w_v - w_qd[VW-1:0];
    assign w_sine     = sine_at(r_prod2[K2+SPTS_W-1:K2]);
    assign w_sa_full  = w_sine * r_attack;
    assign w_lvl_full = r_sa * r_release;

    // input capture and start arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_step_in <= i_step_size;
            r_len     <= i_length;
            r_len_rem <= TICKS_W'(i_length * TICK_REM);
        end
        if (i_cmd.start_mul) begin
            r_sprod <= r_len_rem * TICK_RECIP_V;
        end
    end

    // tick pipeline working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.tk_acc) begin
            r_end <= (r_ticks == '0);
        end
        if (i_cmd.tk_div) begin
            r_prod1 <= w_v * M1_V;
        end
        if (i_cmd.tk_mod) begin
            r_idx <= IW'(w_rem);
        end
        if (i_cmd.tk_scl) begin
            r_prod2 <= {r_idx, {SPTS_W{1'b0}}} * M2_V;
        end
        if (i_cmd.tk_att) begin
            r_sa <= LEVEL_W'(w_sa_full >> ENV_SHIFT);
        end
    end

    // tone state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_step    <= '0;
            r_ticks   <= '0;
            r_attack  <= '0;
            r_release <= '0;
            r_active  <= 1'b0;
            r_drive   <= 1'b1;
            r_level   <= '0;
        end else begin
            if (i_cmd.stop) begin
                r_drive <= 1'b0;
            end
            if (i_cmd.start_fin) begin
                r_step    <= r_step_in;
                r_attack  <= '0;
                r_release <= ENV_FULL;
                r_ticks   <= TICKS_W'(r_len * TICK_WHOLE)
                           + TICKS_W'(r_sprod >> TICK_SHIFT);
                r_active  <= 1'b1;
                r_drive   <= 1'b1;
            end
            if (i_cmd.tk_acc) begin
                r_phase <= r_phase + PHASE_WIDTH'(r_step);
                if (r_attack < ENV_FULL) begin
                    r_attack <= r_attack + 1'b1;
                end
                if (r_ticks < TICKS_W'(ENV_FULL)) begin
                    r_release <= ENV_W'(r_ticks);
                end
                if (r_ticks == '0) begin
                    r_active <= 1'b0;
                end else begin
                    r_ticks <= r_ticks - 1'b1;
                end
            end
            if (i_cmd.tk_rel) begin
                if (r_end || r_step == '0) begin
                    r_level <= '0;
                end else begin
                    r_level <= LEVEL_W'(w_lvl_full >> ENV_SHIFT);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_level   <= r_level;
            r_out_playing <= r_active;
            r_out_drive   <= r_drive;
        end
    end

    // level may lag the end of a tone only until the final tick clears it
    `STG_ASSERT_NEVER(a_idle_level, i_clk, i_rst_n, !r_active && !r_end && r_level != '0)
    `STG_ASSERT_NEVER(a_attack_cap, i_clk, i_rst_n, r_attack > ENV_FULL)
    `STG_ASSERT(a_ticks_down, i_clk, i_rst_n, (i_cmd.tk_acc && r_ticks != '0) |=> (r_ticks == $past(r_ticks) - 1'b1))

endmodule

@@ tb/sv/sine_tone_generator_with_envelope_core_tb.sv @@
// self-checking testbench for the sine tone generator with envelope
`timescale 1ns / 1ps

module sine_tone_generator_with_envelope_core_tb;
    import stgen_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_ITEMS = 1625;
    localparam int unsigned CALM_ITEMS   = 400;
    localparam int unsigned IDLE_PCT     = 35;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned ENV_TOP      = 64;
    localparam int unsigned ENV_BITS     = 6;
    localparam int unsigned LEN_MUL      = 1000;
    localparam int unsigned LEN_DIV      = 51;

    // first quarter of a 128-point sine, magnitude above mid scale
    localparam logic [6:0] QUARTER_SINE [0:32] = '{
        7'd0,   7'd6,   7'd12,  7'd19,  7'd25,  7'd31,  7'd37,  7'd43,  7'd49,
        7'd54,  7'd60,  7'd65,  7'd71,  7'd76,  7'd81,  7'd85,  7'd90,  7'd94,
        7'd98,  7'd102, 7'd106, 7'd109, 7'd112, 7'd115, 7'd117, 7'd120, 7'd122,
        7'd123, 7'd125, 7'd126, 7'd126, 7'd127, 7'd127
    };

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               playing;
        logic               drive;
    } t_tone_status;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [OP_W-1:0]    i_operation;
    logic [STEP_W-1:0]  i_step_size;
    logic [LEN_W-1:0]   i_length;
    logic               o_valid;
    logic               i_stall;
    logic [LEVEL_W-1:0] o_pwm_level;
    logic               o_playing;
    logic               o_output_enabled;

    // predicted tone state
    logic [15:0]        ph_acc;
    logic [STEP_W-1:0]  ph_step;
    logic [TICKS_W-1:0] ticks_rem;
    logic [ENV_W-1:0]   att_lvl;
    logic [ENV_W-1:0]   rel_lvl;
    logic               tone_on;
    logic               drive_on;
    logic [LEVEL_W-1:0] cur_level;

    t_tone_status awaited_status[$];
    t_tone_status got_status;
    t_tone_status want_status;
    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    int unsigned  counted_items;
    bit           idle_en;

    sine_tone_generator_with_envelope_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_step_size      (i_step_size),
        .i_length         (i_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pwm_level      (o_pwm_level),
        .o_playing        (o_playing),
        .o_output_enabled (o_output_enabled)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // unsigned sine sample centered on 128
    function automatic logic [7:0] sine_sample(input logic [6:0] p);
        if (p <= 7'd32) begin
            return 8'd128 + 8'(QUARTER_SINE[p]);
        end else if (p <= 7'd64) begin
            return 8'd128 + 8'(QUARTER_SINE[7'd64 - p]);
        end else if (p <= 7'd96) begin
            return 8'd128 - 8'(QUARTER_SINE[p - 7'd64]);
        end else begin
            return 8'd128 - 8'(QUARTER_SINE[8'd128 - 8'(p)]);
        end
    endfunction

    // advance the predicted state by one item and queue the status it leaves
    function automatic void predict_tone_status(input logic [OP_W-1:0] op,
                                                input logic [STEP_W-1:0] step,
                                                input logic [LEN_W-1:0] len);
        logic [15:0] rounded;
        int unsigned scaled;
        if (op == OP_TICK && tone_on) begin
            ph_acc  = ph_acc + 16'(ph_step);
            rounded = ph_acc + 16'd4;
            if (att_lvl < ENV_TOP) begin
                att_lvl = att_lvl + 7'd1;
            end
            if (ticks_rem < ENV_TOP) begin
                rel_lvl = ticks_rem[6:0];
            end
            scaled = int'(sine_sample(rounded[9:3])) * int'(att_lvl);
            scaled = ((scaled >> ENV_BITS) * int'(rel_lvl)) >> ENV_BITS;
            cur_level = (ph_step != '0) ? scaled[7:0] : '0;
            // the tick that finds the count at zero ends the tone
            if (ticks_rem == '0) begin
                tone_on   = 1'b0;
                cur_level = '0;
            end else begin
                ticks_rem = ticks_rem - 1'b1;
            end
        end else if (op == OP_START) begin
            ph_step   = step;
            att_lvl   = '0;
            rel_lvl   = 7'(ENV_TOP);
            scaled    = int'(len) * LEN_MUL / LEN_DIV;
            ticks_rem = scaled[TICKS_W-1:0];
            tone_on   = 1'b1;
            drive_on  = 1'b1;
        end else if (op == OP_STOP) begin
            drive_on = 1'b0;
        end
        awaited_status.push_back('{cur_level, tone_on, drive_on});
    endfunction

    function automatic void note_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch in %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    // send one item, idling first at random, and predict once it is taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic [STEP_W-1:0] step,
                             input logic [LEN_W-1:0] len);
        @(negedge i_clk);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_operation = op;
        i_step_size = step;
        i_length    = len;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        counted_items++;
        predict_tone_status(op, step, len);
    endtask

    // receiver stall
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall = i_rst_n && idle_en && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_status = '{o_pwm_level, o_playing, o_output_enabled};
            if (awaited_status.size() == 0) begin
                note_mismatch("result with nothing awaited", 0, 32'(got_status));
            end else begin
                want_status = awaited_status.pop_front();
                if (want_status.level != got_status.level) begin
                    note_mismatch("pwm_level", 32'(want_status.level),
                                  32'(got_status.level));
                end
                if (want_status.playing != got_status.playing) begin
                    note_mismatch("playing", 32'(want_status.playing),
                                  32'(got_status.playing));
                end
                if (want_status.drive != got_status.drive) begin
                    note_mismatch("output_enabled", 32'(want_status.drive),
                                  32'(got_status.drive));
                end
            end
        end
    end

    // ticks and unused codes while idle, stop with nothing playing
    task automatic test_idle_items();
        send_item(OP_TICK, 8'hFF, 16'hFFFF);
        send_item(OP_UNUSED, 8'h00, 16'h0000);
        send_item(OP_STOP, 8'hA5, 16'h5A5A);
        send_item(OP_TICK, 8'h00, 16'h0000);
        send_item(OP_UNUSED, 8'hFF, 16'hFFFF);
    endtask

    // zero length plays one silent tick and ends
    task automatic test_zero_length();
        send_item(OP_START, 8'h55, 16'h0000);
        send_item(OP_TICK, 8'h00, 16'h0000);
        send_item(OP_TICK, 8'h00, 16'h0000);
    endtask

    // zero and full step, full length, restart and stop while playing
    task automatic test_step_extremes();
        int unsigned k;
        send_item(OP_START, 8'h00, 16'h0001);
        for (k = 0; k < 3; k++) begin
            send_item(OP_TICK, 8'h00, 16'h0000);
        end
        send_item(OP_START, 8'hFF, 16'hFFFF);
        for (k = 0; k < 6; k++) begin
            send_item(OP_TICK, 8'h00, 16'h0000);
        end
        send_item(OP_STOP, 8'h00, 16'h0000);
        send_item(OP_TICK, 8'hFF, 16'hFFFF);
        send_item(OP_TICK, 8'h00, 16'h0000);
    endtask

    // random tones mostly played to the end, with stops, unused codes and restarts
    task automatic test_random_tones();
        logic [STEP_W-1:0] step;
        logic [LEN_W-1:0]  len;
        int unsigned       first_item;
        int unsigned       pick;
        int unsigned       n_ticks;
        int unsigned       k;
        first_item = counted_items;
        idle_en    = 1'b0;
        while (counted_items - first_item < RANDOM_ITEMS) begin
            if (counted_items - first_item >= CALM_ITEMS) begin
                idle_en = 1'b1;
            end
            pick = $urandom_range(0, 99);
            step = (pick < 8) ? 8'h00 : (pick < 16) ? 8'hFF : 8'($urandom_range(1, 255));
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = 16'($urandom_range(0, 3));
            end else if (pick < 85) begin
                len = 16'($urandom_range(4, 12));
            end else begin
                len = 16'($urandom);
            end
            send_item(OP_START, step, len);
            // long tones are cut short by the next start
            if (ticks_rem > 240) begin
                n_ticks = $urandom_range(20, 120);
            end else if ($urandom_range(0, 9) == 0) begin
                n_ticks = $urandom_range(0, ticks_rem);
            end else begin
                n_ticks = ticks_rem + ticks_rem / 16 + $urandom_range(2, 6);
            end
            for (k = 0; k < n_ticks; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_item(OP_STOP, 8'($urandom), 16'($urandom));
                end else if (pick < 6) begin
                    send_item(OP_UNUSED, 8'($urandom), 16'($urandom));
                end else begin
                    send_item(OP_TICK, 8'($urandom), 16'($urandom));
                end
            end
        end
    endtask

    // reset, tests in turn, drain and verdict
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_TICK;
        i_step_size    = '0;
        i_length       = '0;
        idle_en        = 1'b1;
        mismatch_count = 0;
        counted_items  = 0;
        ph_acc         = '0;
        ph_step        = '0;
        ticks_rem      = '0;
        att_lvl        = '0;
        rel_lvl        = '0;
        tone_on        = 1'b0;
        drive_on       = 1'b1;
        cur_level      = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_idle_items();
        test_zero_length();
        test_step_extremes();
        test_random_tones();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (awaited_status.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
